// File: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Property checked at every rising clock edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// File: design/bfha_pkg.sv
`timescale 1ns / 1ps
package bfha_pkg;

  localparam int unsigned ADDR_W = 8;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned STS_W  = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [SIZE_W-1:0] TOTAL_RESET = 9'd100;

  typedef struct packed {
    logic init;
    logic load;
    logic rd_en;
    logic apply;
  } ctrl_cmd_t;

endpackage

// File: design/bfha_if.sv
`timescale 1ns / 1ps
interface bfha_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [bfha_pkg::SIZE_W-1:0]  block_size;
  logic [bfha_pkg::ADDR_W-1:0]  block_address;
  modport source (output valid, operation, block_size, block_address, input ready);
  modport sink (input valid, operation, block_size, block_address, output ready);
endinterface

interface bfha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bfha_pkg::ADDR_W-1:0]  granted_address;
  logic [bfha_pkg::STS_W-1:0]   status;
  modport source (output valid, granted_address, status, input ready);
  modport sink (input valid, granted_address, status, output ready);
endinterface

interface bfha_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfha_pkg::SIZE_W-1:0]  total_size;
  modport source (output valid, total_size, input ready);
  modport sink (input valid, total_size, output ready);
endinterface

// File: design/bfha_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfha_ctrl #(
  parameter int unsigned MAX_HOLES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  input  logic                          cfg_valid_i,
  output bfha_pkg::ctrl_cmd_t           cmd_o,
  output logic [$clog2(MAX_HOLES)-1:0]  rd_idx_o
);

  localparam int unsigned IW = $clog2(MAX_HOLES);
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
    end else if (cfg_valid_i) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_INIT: begin
          state_q <= S_IDLE;
        end
        S_IDLE: begin
          cnt_q <= '0;
          if (req_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MAX_HOLES)) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_INIT;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign rsp_valid_o = (state_q == S_RESP);
  assign rd_idx_o    = cnt_q[IW-1:0];

  always_comb begin
    cmd_o       = '0;
    cmd_o.init  = (state_q == S_INIT);
    cmd_o.load  = req_ready_o && req_valid_i;
    cmd_o.rd_en = (state_q == S_SCAN) && (cnt_q != CW'(MAX_HOLES));
    cmd_o.apply = (state_q == S_APPLY);
  end

  `ASSERT_CLK(a_no_overlap, clk_i, rst_ni, !(req_ready_o && rsp_valid_o))
  `ASSERT_CLK(a_load_scan, clk_i, rst_ni, cmd_o.load |=> (state_q == S_SCAN && cnt_q == '0))
  `ASSERT_CLK(a_cfg_init, clk_i, rst_ni, cfg_valid_i |=> cmd_o.init)

endmodule

// File: design/bfha_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfha_dp #(
  parameter int unsigned MEMORY_WORDS = 256,
  parameter int unsigned MAX_HOLES    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bfha_pkg::ctrl_cmd_t                cmd_i,
  input  logic [$clog2(MAX_HOLES)-1:0]       rd_idx_i,
  input  logic                               cfg_we_i,
  input  logic [bfha_pkg::SIZE_W-1:0]        cfg_total_i,
  input  logic                               op_i,
  input  logic [bfha_pkg::SIZE_W-1:0]        size_i,
  input  logic [bfha_pkg::ADDR_W-1:0]        addr_i,
  output logic [bfha_pkg::ADDR_W-1:0]        granted_o,
  output logic [bfha_pkg::STS_W-1:0]         status_o
);

  localparam int unsigned IW = $clog2(MAX_HOLES);
  localparam int unsigned W  = bfha_pkg::SIZE_W;

  // Hole store: base and length per entry, validity in flip-flops.
  logic [W-1:0]         base_mem [MAX_HOLES];
  logic [W-1:0]         len_mem  [MAX_HOLES];
  logic [MAX_HOLES-1:0] valid_q;

  logic [W-1:0] total_q;
  logic [W-1:0] lim;

  logic          op_q, skip_q;
  logic [W-1:0]  size_q, addr_q, fsize_q, end_q;

  logic          eval_q;
  logic [IW-1:0] eidx_q;
  logic [W-1:0]  rbase_q, rlen_q;

  logic          bf_q, lf_q, rf_q, ef_q;
  logic [IW-1:0] bi_q, li_q, ri_q, ei_q;
  logic [W-1:0]  bb_q, bl_q, lb_q, ll_q, rl_q;

  logic [bfha_pkg::ADDR_W-1:0] gnt_q;
  logic [bfha_pkg::STS_W-1:0]  sts_q;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [W-1:0]  wr_base, wr_len;
  logic          vclr, vset;
  logic [IW-1:0] vidx;
  logic [bfha_pkg::ADDR_W-1:0] gnt_d;
  logic [bfha_pkg::STS_W-1:0]  sts_d;

  logic [W-1:0]  room;
  logic          cur_v;
  logic [W:0]    cur_end;
  logic          fit, better;

  assign lim = (32'(total_q) > 32'(MEMORY_WORDS)) ? W'(MEMORY_WORDS) : total_q;
  assign room = lim - W'(addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bfha_pkg::TOTAL_RESET;
    end else if (cfg_we_i) begin
      total_q <= cfg_total_i;
    end
  end

  // Request capture with free-range clipping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      size_q  <= size_i;
      addr_q  <= W'(addr_i);
      skip_q  <= (W'(addr_i) >= lim) || (size_i == '0);
      fsize_q <= (size_i > room) ? room : size_i;
      end_q   <= W'(addr_i) + ((size_i > room) ? room : size_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rbase_q <= base_mem[rd_idx_i];
      rlen_q  <= len_mem[rd_idx_i];
    end
    if (wr_en) begin
      base_mem[wr_idx] <= wr_base;
      len_mem[wr_idx]  <= wr_len;
    end
  end

  assign cur_v   = valid_q[eidx_q];
  assign cur_end = {1'b0, rbase_q} + {1'b0, rlen_q};
  assign fit     = cur_v && (rlen_q >= size_q);
  assign better  = !bf_q || (rlen_q < bl_q) || ((rlen_q == bl_q) && (rbase_q < bb_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q <= 1'b0;
      eidx_q <= '0;
      bf_q   <= 1'b0;
      lf_q   <= 1'b0;
      rf_q   <= 1'b0;
      ef_q   <= 1'b0;
    end else begin
      eval_q <= cmd_i.rd_en;
      eidx_q <= rd_idx_i;
      if (cmd_i.load) begin
        bf_q <= 1'b0;
        lf_q <= 1'b0;
        rf_q <= 1'b0;
        ef_q <= 1'b0;
      end else if (eval_q) begin
        if (op_q == bfha_pkg::OP_ALLOC) begin
          if (fit && better) begin
            bf_q <= 1'b1;
          end
        end else if (!cur_v) begin
          if (!ef_q) begin
            ef_q <= 1'b1;
          end
        end else if (!lf_q && (cur_end == {1'b0, addr_q})) begin
          lf_q <= 1'b1;
        end else if (!rf_q && (rbase_q == end_q)) begin
          rf_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_q) begin
      if (op_q == bfha_pkg::OP_ALLOC) begin
        if (fit && better) begin
          bi_q <= eidx_q;
          bb_q <= rbase_q;
          bl_q <= rlen_q;
        end
      end else if (!cur_v) begin
        if (!ef_q) begin
          ei_q <= eidx_q;
        end
      end else if (!lf_q && (cur_end == {1'b0, addr_q})) begin
        li_q <= eidx_q;
        lb_q <= rbase_q;
        ll_q <= rlen_q;
      end else if (!rf_q && (rbase_q == end_q)) begin
        ri_q <= eidx_q;
        rl_q <= rlen_q;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_base = '0;
    wr_len  = '0;
    vclr    = 1'b0;
    vset    = 1'b0;
    vidx    = '0;
    gnt_d   = '0;
    sts_d   = bfha_pkg::ST_DONE;
    if (cmd_i.init) begin
      wr_en  = 1'b1;
      wr_len = lim;
    end else if (cmd_i.apply) begin
      if (op_q == bfha_pkg::OP_ALLOC) begin
        if (!bf_q) begin
          sts_d = bfha_pkg::ST_NO_FIT;
        end else begin
          gnt_d = bb_q[bfha_pkg::ADDR_W-1:0];
          if (bl_q == size_q) begin
            vclr = 1'b1;
            vidx = bi_q;
          end else begin
            wr_en   = 1'b1;
            wr_idx  = bi_q;
            wr_base = bb_q + size_q;
            wr_len  = bl_q - size_q;
          end
        end
      end else if (!skip_q) begin
        if (lf_q && rf_q) begin
          wr_en   = 1'b1;
          wr_idx  = li_q;
          wr_base = lb_q;
          wr_len  = ll_q + fsize_q + rl_q;
          vclr    = 1'b1;
          vidx    = ri_q;
        end else if (lf_q) begin
          wr_en   = 1'b1;
          wr_idx  = li_q;
          wr_base = lb_q;
          wr_len  = ll_q + fsize_q;
        end else if (rf_q) begin
          wr_en   = 1'b1;
          wr_idx  = ri_q;
          wr_base = addr_q;
          wr_len  = rl_q + fsize_q;
        end else if (ef_q) begin
          wr_en   = 1'b1;
          wr_idx  = ei_q;
          wr_base = addr_q;
          wr_len  = fsize_q;
          vset    = 1'b1;
          vidx    = ei_q;
        end else begin
          sts_d = bfha_pkg::ST_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.init) begin
      valid_q <= {{(MAX_HOLES-1){1'b0}}, (lim != '0)};
    end else if (vclr) begin
      valid_q[vidx] <= 1'b0;
    end else if (vset) begin
      valid_q[vidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      gnt_q <= gnt_d;
      sts_q <= sts_d;
    end
  end

  assign granted_o = gnt_q;
  assign status_o  = sts_q;

  `ASSERT_CLK(a_best_fits, clk_i, rst_ni, (bf_q && op_q == bfha_pkg::OP_ALLOC) |-> (bl_q >= size_q))
  `ASSERT_CLK(a_one_vop, clk_i, rst_ni, !(vclr && vset))
  `ASSERT_CLK(a_apply_quiet, clk_i, rst_ni, cmd_i.apply |-> !(eval_q || cmd_i.rd_en || cmd_i.load))

endmodule

// File: design/best_fit_hole_allocator.sv
`timescale 1ns / 1ps
// Best-fit hole allocator. The block keeps a table of MAX_HOLES free holes over a
// memory of total_size words (limited to MEMORY_WORDS); after reset, and after each
// write of total_size, one hole covers the whole memory. An allocate word picks the
// smallest hole that fits, ties going to the lowest base, and returns its base; a free
// word returns a range and merges it with the holes that touch it. Every request word
// gives exactly one response word carrying the granted address and a status of done,
// no fitting hole, or hole table full. One request is handled at a time. After a
// request is accepted, the hole table is scanned through its single registered read
// port, one entry per cycle, the last entry read is evaluated, the table is updated,
// and then the response is offered. The next request can be accepted only after the
// response handshake and the return to idle. After reset, and after a configuration
// write, the block builds the initial hole before it accepts a request. The
// configuration port is always ready.
module best_fit_hole_allocator #(
  parameter int unsigned MEMORY_WORDS = 256,
  parameter int unsigned MAX_HOLES    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfha_req_if.sink   req,
  bfha_rsp_if.source rsp,
  bfha_cfg_if.sink   cfg
);

  bfha_pkg::ctrl_cmd_t            cmd;
  logic [$clog2(MAX_HOLES)-1:0]   rd_idx;

  // Always taken; user must send configuration words only while idle, unenforced here.
  assign cfg.ready = 1'b1;

  // The controller sequences each request: capture, table scan, update, response.
  bfha_ctrl #(
    .MAX_HOLES (MAX_HOLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .cfg_valid_i (cfg.valid),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx)
  );

  // The datapath holds the hole table, the best-fit and merge search, and the result.
  bfha_dp #(
    .MEMORY_WORDS (MEMORY_WORDS),
    .MAX_HOLES    (MAX_HOLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_idx_i    (rd_idx),
    .cfg_we_i    (cfg.valid),
    .cfg_total_i (cfg.total_size),
    .op_i        (req.operation),
    .size_i      (req.block_size),
    .addr_i      (req.block_address),
    .granted_o   (rsp.granted_address),
    .status_o    (rsp.status)
  );

endmodule
